/* src/rtcm3_frame_deframer_crc24q_unit_assert.svh */
// Assertion macros for the checker file of the RTCM3 deframer.
`ifndef RTCM3_FRAME_DEFRAMER_CRC24Q_UNIT_ASSERT_SVH
`define RTCM3_FRAME_DEFRAMER_CRC24Q_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdf assertion failed");

// Next-cycle implication that is also checked across reset.
`define RDF_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rdf assertion failed");

`endif

/* src/rdf_pkg.sv */
// Shared types, constants and the CRC-24Q byte step for the RTCM3 deframer.
package rdf_pkg;

  localparam logic [7:0]  PREAMBLE   = 8'hD3;
  localparam logic [24:0] CRC_POLY   = 25'h1864CFB;
  localparam logic [9:0]  CRC_BYTES  = 10'd3;
  localparam logic [1:0]  TYPE_BYTES = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_t;

  // What the back end has to do with a byte.
  typedef enum logic [2:0] {
    OP_PASS    = 3'd0,
    OP_PRE     = 3'd1,
    OP_LEN_HI  = 3'd2,
    OP_LEN_LO  = 3'd3,
    OP_PAYLOAD = 3'd4,
    OP_CRC     = 3'd5
  } op_t;

  // Which part of the message type a byte feeds.
  typedef enum logic [1:0] {
    TP_NONE = 2'd0,
    TP_HI   = 2'd1,
    TP_LO   = 2'd2
  } type_pos_t;

  // Select codes for the expected CRC byte, most significant first.
  localparam logic [1:0] CSEL_HI  = 2'd3;
  localparam logic [1:0] CSEL_MID = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    op_t        op;
    type_pos_t  type_pos;
    logic [1:0] crc_sel;
    logic       last;
  } entry_t;

  function automatic logic [23:0] crc24q_step(input logic [23:0] crc, input logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage

/* src/rdf_front.sv */
// Front end: accepts input beats, tracks frame structure and tags each byte.
module rdf_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic [7:0]     in_tdata,
  input  logic           q_ready,
  output logic           push,
  output rdf_pkg::entry_t entry
);
  import rdf_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [9:0] left_r, left_nxt;
  logic [1:0] len_hi_r, len_hi_nxt;
  logic [1:0] ofs_r, ofs_nxt;
  logic       accept;
  logic [9:0] len_full;
  logic [1:0] ofs_inc;

  assign accept   = in_tvalid && q_ready;
  assign push     = accept;
  assign len_full = {len_hi_r, in_tdata};
  assign ofs_inc  = (ofs_r == TYPE_BYTES) ? ofs_r : ofs_r + 2'd1;

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    len_hi_nxt = len_hi_r;
    ofs_nxt    = ofs_r;
    if (accept) begin
      case (phase_r)
        PH_LEN_HI: begin
          len_hi_nxt = in_tdata[1:0];
          phase_nxt  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_full == 10'd0) begin
            left_nxt  = CRC_BYTES;
            phase_nxt = PH_CRC;
          end else begin
            left_nxt  = len_full;
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          ofs_nxt = ofs_inc;
          if (left_r == 10'd1) begin
            left_nxt  = CRC_BYTES;
            phase_nxt = PH_CRC;
          end else begin
            left_nxt = left_r - 10'd1;
          end
        end
        PH_CRC: begin
          ofs_nxt  = ofs_inc;
          left_nxt = left_r - 10'd1;
          if (left_r == 10'd1) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (in_tdata == PREAMBLE) begin
            phase_nxt  = PH_LEN_HI;
            left_nxt   = 10'd0;
            len_hi_nxt = 2'd0;
            ofs_nxt    = 2'd0;
          end
        end
      endcase
    end
  end

  always_comb begin
    entry.data     = in_tdata;
    entry.op       = OP_PASS;
    entry.type_pos = TP_NONE;
    entry.crc_sel  = left_r[1:0];
    entry.last     = 1'b0;
    case (phase_r)
      PH_LEN_HI:  entry.op = OP_LEN_HI;
      PH_LEN_LO:  entry.op = OP_LEN_LO;
      PH_PAYLOAD: entry.op = OP_PAYLOAD;
      PH_CRC: begin
        entry.op   = OP_CRC;
        entry.last = (left_r == 10'd1);
      end
      default:    entry.op = (in_tdata == PREAMBLE) ? OP_PRE : OP_PASS;
    endcase
    if (phase_r == PH_PAYLOAD || phase_r == PH_CRC) begin
      if (ofs_r == 2'd0) begin
        entry.type_pos = TP_HI;
      end else if (ofs_r == 2'd1) begin
        entry.type_pos = TP_LO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      left_r   <= '0;
      len_hi_r <= '0;
      ofs_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      len_hi_r <= len_hi_nxt;
      ofs_r    <= ofs_nxt;
    end
  end

endmodule

/* src/rdf_queue.sv */
// Short queue of tagged bytes between the front and back ends.
module rdf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rdf_pkg::entry_t push_entry,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output rdf_pkg::entry_t head
);
  import rdf_pkg::*;

  entry_t         q_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign ready   = (cnt_r != QDEPTH[QAW:0]);
  assign valid   = (cnt_r != '0);
  assign head    = q_r[rd_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

endmodule

/* src/rdf_back.sv */
// Back end: runs the CRC, gathers type and length, and drives the output register.
module rdf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  rdf_pkg::entry_t q_head,
  output logic            q_pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);
  import rdf_pkg::*;

  logic [23:0] crc_r, crc_nxt;
  logic        mism_r, mism_nxt;
  logic [11:0] type_r, type_nxt;
  logic [9:0]  len_r, len_nxt;
  logic [7:0]  b, expect_byte;
  logic        miss, fend;

  logic        vld_r;
  logic [7:0]  byte_r;
  logic        inf_r, end_r, ok_r;
  logic [11:0] msg_r;
  logic [9:0]  plen_r;

  assign b     = q_head.data;
  assign q_pop = q_valid && (!vld_r || out_tready);
  assign fend  = (q_head.op == OP_CRC) && q_head.last;
  assign miss  = (b != expect_byte);

  always_comb begin
    case (q_head.crc_sel)
      CSEL_HI:  expect_byte = crc_r[23:16];
      CSEL_MID: expect_byte = crc_r[15:8];
      default:  expect_byte = crc_r[7:0];
    endcase
  end

  always_comb begin
    crc_nxt  = crc_r;
    mism_nxt = mism_r;
    len_nxt  = len_r;
    type_nxt = type_r;
    case (q_head.op)
      OP_PRE: begin
        crc_nxt  = crc24q_step(24'h000000, b);
        mism_nxt = 1'b0;
        len_nxt  = '0;
        type_nxt = '0;
      end
      OP_LEN_HI: begin
        crc_nxt = crc24q_step(crc_r, b);
        len_nxt = {b[1:0], 8'h00};
      end
      OP_LEN_LO: begin
        crc_nxt = crc24q_step(crc_r, b);
        len_nxt = {len_r[9:8], b};
      end
      OP_PAYLOAD: crc_nxt = crc24q_step(crc_r, b);
      OP_CRC:     mism_nxt = mism_r | miss;
      default:    crc_nxt = crc_r;
    endcase
    case (q_head.type_pos)
      TP_HI:   type_nxt = {b, 4'h0};
      TP_LO:   type_nxt = {type_r[11:4], b[7:4]};
      default: type_nxt = type_nxt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= '0;
      mism_r <= 1'b0;
      type_r <= '0;
      len_r  <= '0;
      vld_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        crc_r  <= crc_nxt;
        mism_r <= mism_nxt;
        type_r <= type_nxt;
        len_r  <= len_nxt;
        vld_r  <= 1'b1;
      end else if (out_tready) begin
        vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      byte_r <= b;
      inf_r  <= (q_head.op != OP_PASS);
      end_r  <= fend;
      ok_r   <= fend && !mism_nxt;
      msg_r  <= fend ? type_nxt : 12'h000;
      plen_r <= fend ? len_r : 10'h000;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {1'b0, plen_r, msg_r, ok_r, byte_r};
  assign out_tuser  = inf_r;
  assign out_tlast  = end_r;

endmodule

/* src/rtcm3_frame_deframer_crc24q_unit.sv */
// Top level of the RTCM3 deframer with CRC-24Q check.
//
//   channel | direction | bits                         | meaning
//   in_     | slave     | tdata[7:0]                   | one stream byte per beat
//   out_    | master    | tdata[31:0], tuser, tlast    | byte with frame status
//
// One byte is accepted per cycle while the tag queue has room, and each produces exactly one output beat.
// An accepted byte passes through the tag queue into the output register, and its result
// is taken from that register. The CRC byte step and the counters are computed combinationally.
// A stalled output fills the four-entry tag queue; in_tready drops only when it is full.
// Reset is synchronous and active low; no clearing pass is needed.
module rtcm3_frame_deframer_crc24q_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [8] crc_ok, [20:9] msg_type,
                                  // [30:21] payload_len, [31] zero
  output logic        out_tuser,  // [0] in_frame
  output logic        out_tlast   // frame_end
);
  import rdf_pkg::*;

  entry_t push_entry, head;
  logic   push, q_ready, q_valid, q_pop;

  assign in_tready = q_ready;

  rdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .push      (push),
    .entry     (push_entry)
  );

  rdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (head)
  );

  rdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* src/rdf_checker.sv */
// Port-level checker for the RTCM3 deframer, bound to the top level.
`include "rtcm3_frame_deframer_crc24q_unit_assert.svh"

module rdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // An input beat that waits keeps its contents.
  `RDF_ASSERT_NEXT(a_in_hold, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata))

  // A stalled beat keeps its contents.
  `RDF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A frame end is always a byte inside a frame.
  `RDF_ASSERT_NOW(a_end_in_frame, out_tvalid && out_tlast, out_tuser)

  // Frame status fields are zero on every beat but the frame end.
  `RDF_ASSERT_NOW(a_status_zero, out_tvalid && !out_tlast, out_tdata[31:8] == 24'h000000)

  // Nothing is offered in the cycle after reset.
  `RDF_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_tvalid)

endmodule

bind rtcm3_frame_deframer_crc24q_unit rdf_checker u_rdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
